// ===== design/rcpd_pkg.sv =====
// Shared types and constants for the radio command packet decoder.
// No dependencies; imported by every module of the block.
package rcpd_pkg;

    localparam int SHORT_LEN    = 9;
    localparam int LONG_LEN     = 19;
    localparam int COUNT_W      = 5;
    localparam int HOP_CHANNELS = 4;
    localparam int HOP_IDX_W    = $clog2(HOP_CHANNELS);

    localparam logic [15:0] RATE_LOW_Q16 = 16'd21627;
    localparam logic [15:0] RATE_MID_Q16 = 16'd43254;

    typedef enum logic [1:0] {
        CFG_PROTOCOL_MODE = 2'd0,
        CFG_BIND_ID_LOW   = 2'd1,
        CFG_BIND_ID_HIGH  = 2'd2
    } cfg_index_t;

    typedef enum logic [1:0] {
        SCALE_NONE,
        SCALE_LOW,
        SCALE_MID
    } scale_t;

    // packet bytes as seen at the transfer that completes the packet
    typedef struct packed {
        logic                        complete;
        logic [LONG_LEN-1:0][7:0]    bytes;
    } frame_t;

    // decoded, clamped commands before rate scaling
    typedef struct packed {
        logic        [9:0] throttle_cmd;
        logic signed [9:0] roll_cmd;
        logic signed [9:0] pitch_cmd;
        logic signed [9:0] yaw_cmd;
        logic signed [9:0] aux_flip;
        logic        [6:0] hop_channel;
        logic              hop_valid;
        scale_t            scale;
    } mid_t;

    typedef struct packed {
        logic        [9:0] throttle_cmd;
        logic signed [9:0] roll_cmd;
        logic signed [9:0] pitch_cmd;
        logic signed [9:0] yaw_cmd;
        logic signed [9:0] aux_flip;
        logic        [6:0] hop_channel;
        logic              hop_valid;
    } result_t;

endpackage

// ===== design/rcpd_collect.sv =====
// Byte counter and packet store; presents the packet bytes on completion.
// Depends on rcpd_pkg.
module rcpd_collect (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            accept,
    input  logic [7:0]      payload_byte,
    input  logic            packet_start,
    input  logic            protocol_mode,
    output rcpd_pkg::frame_t frame
);
    import rcpd_pkg::*;

    localparam logic [COUNT_W-1:0] LEN_SHORT = COUNT_W'(SHORT_LEN);
    localparam logic [COUNT_W-1:0] LEN_LONG  = COUNT_W'(LONG_LEN);

    logic [7:0]         store_reg [LONG_LEN];
    logic [COUNT_W-1:0] count_reg;
    logic [COUNT_W-1:0] count_next;
    logic [COUNT_W-1:0] count_eff;
    logic [COUNT_W-1:0] len;
    logic               write_en;

    always_comb
    begin
        count_eff  = packet_start ? '0 : count_reg;
        len        = protocol_mode ? LEN_LONG : LEN_SHORT;
        write_en   = accept && (count_eff < len);
        count_next = write_en ? count_eff + 1'b1 : count_reg;
        frame.complete = write_en && (count_eff + 1'b1 == len);
        for (int i = 0; i < LONG_LEN; i++)
        begin
            frame.bytes[i] = (count_eff == COUNT_W'(i)) ? payload_byte : store_reg[i];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else
        begin
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (write_en)
        begin
            store_reg[count_eff] <= payload_byte;
        end
    end

endmodule

// ===== design/rcpd_decode.sv =====
// Field decode, clamping, flip latch and hop sequencing; registers the result.
// Depends on rcpd_pkg.
module rcpd_decode (
    input  logic           clk,
    input  logic           rst_n,
    input  rcpd_pkg::frame_t frame,
    input  logic           protocol_mode,
    input  logic [7:0]     bind_id_low,
    input  logic [7:0]     bind_id_high,
    output rcpd_pkg::mid_t mid
);
    import rcpd_pkg::*;

    localparam logic signed [9:0] CMD_MAX = 10'sd500;
    localparam logic signed [9:0] CMD_MIN = -10'sd500;

    function automatic logic signed [9:0] sat_cmd(input logic signed [17:0] v);
        logic signed [9:0] r;
        if (v > 18'sd500)
            r = CMD_MAX;
        else if (v < -18'sd500)
            r = CMD_MIN;
        else
            r = v[9:0];
        return r;
    endfunction

    mid_t                 mid_reg;
    mid_t                 mid_next;
    logic signed [9:0]    aux_reg;
    logic signed [9:0]    aux_next;
    logic [HOP_IDX_W-1:0] hop_idx_reg;
    logic [HOP_IDX_W-1:0] hop_idx_next;

    logic [9:0]           thr0;
    logic signed [17:0]   thr1;
    logic signed [9:0]    pitch1;
    logic [6:0]           chan;

    always_comb
    begin
        mid_next     = mid_reg;
        aux_next     = aux_reg;
        hop_idx_next = hop_idx_reg;
        thr0   = {frame.bytes[0], 2'b00};
        thr1   = $signed({2'b00, frame.bytes[14], frame.bytes[13]}) - 18'sd1000;
        pitch1 = 10'sd0 - sat_cmd($signed({{2{frame.bytes[12][7]}},
                 frame.bytes[12], frame.bytes[11]}) - 18'sd1500);

        case (hop_idx_reg)
            2'd0:    chan = 7'({4'b0, bind_id_low[3:0]} + 8'h03);
            2'd1:    chan = 7'({4'b0, bind_id_low[7:4]} + 8'h16);
            2'd2:    chan = 7'({4'b0, bind_id_high[3:0]} + 8'h2D);
            default: chan = 7'({4'b0, bind_id_high[7:4]} + 8'h40);
        endcase

        if (frame.complete)
        begin
            if (!protocol_mode)
            begin
                mid_next.throttle_cmd = (thr0 > 10'd1000) ? 10'd1000 : thr0;
                mid_next.roll_cmd  = sat_cmd(18'($signed({1'b0, frame.bytes[4], 2'b00}))
                                     - 18'sd512);
                mid_next.pitch_cmd = sat_cmd(18'($signed({1'b0, frame.bytes[3], 2'b00}))
                                     - 18'sd512);
                mid_next.yaw_cmd   = sat_cmd(18'($signed({1'b0, frame.bytes[1], 2'b00}))
                                     - 18'sd512);
                if (frame.bytes[7][3:0] != 4'h0)
                begin
                    if (frame.bytes[3] > 8'hF0)
                        aux_next = CMD_MAX;
                    if (frame.bytes[3] < 8'h0F)
                        aux_next = CMD_MIN;
                end
                mid_next.hop_channel = 7'd0;
                mid_next.hop_valid   = 1'b0;
                mid_next.scale       = SCALE_NONE;
            end
            else
            begin
                if (thr1 < 18'sd0)
                    mid_next.throttle_cmd = 10'd0;
                else if (thr1 > 18'sd1000)
                    mid_next.throttle_cmd = 10'd1000;
                else
                    mid_next.throttle_cmd = thr1[9:0];
                mid_next.roll_cmd  = 10'sd0 - sat_cmd($signed({{2{frame.bytes[10][7]}},
                                     frame.bytes[10], frame.bytes[9]}) - 18'sd1500);
                mid_next.pitch_cmd = pitch1;
                mid_next.yaw_cmd   = sat_cmd($signed({6'b0, frame.bytes[16][3:0],
                                     frame.bytes[15]}) - 18'sd1500);
                if (frame.bytes[16][4])
                begin
                    if (pitch1 > 10'sd450)
                        aux_next = CMD_MAX;
                    if (pitch1 < -10'sd450)
                        aux_next = CMD_MIN;
                end
                case (frame.bytes[17])
                    8'd0:    mid_next.scale = SCALE_LOW;
                    8'd1:    mid_next.scale = SCALE_MID;
                    default: mid_next.scale = SCALE_NONE;
                endcase
                mid_next.hop_channel = chan;
                mid_next.hop_valid   = 1'b1;
                hop_idx_next = (hop_idx_reg == HOP_IDX_W'(HOP_CHANNELS - 1)) ? '0
                               : hop_idx_reg + 1'b1;
            end
            mid_next.aux_flip = aux_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            aux_reg     <= '0;
            hop_idx_reg <= HOP_IDX_W'(1);
        end
        else
        begin
            aux_reg     <= aux_next;
            hop_idx_reg <= hop_idx_next;
        end
    end

    always_ff @(posedge clk)
    begin
        mid_reg <= mid_next;
    end

    assign mid = mid_reg;

endmodule

// ===== design/rcpd_scale.sv =====
// Rate scaling of the stick axes (Q0.16, magnitude truncated) into the output register.
// Depends on rcpd_pkg.
module rcpd_scale (
    input  logic              clk,
    input  logic              load,
    input  rcpd_pkg::mid_t    mid,
    output rcpd_pkg::result_t res
);
    import rcpd_pkg::*;

    function automatic logic signed [9:0] scale_axis(input logic signed [9:0] v,
                                                     input logic [15:0] k);
        logic [9:0]  neg;
        logic [8:0]  mag;
        logic [24:0] prod;
        logic [9:0]  m;
        neg  = 10'd0 - v;
        mag  = v[9] ? neg[8:0] : v[8:0];
        prod = {16'd0, mag} * {9'd0, k};
        m    = {1'b0, prod[24:16]};
        return v[9] ? $signed(10'd0 - m) : $signed(m);
    endfunction

    result_t     res_reg;
    result_t     res_next;
    logic [15:0] k;

    always_comb
    begin
        case (mid.scale)
            SCALE_LOW: k = RATE_LOW_Q16;
            SCALE_MID: k = RATE_MID_Q16;
            default:   k = 16'd0;
        endcase
        res_next.throttle_cmd = mid.throttle_cmd;
        res_next.aux_flip     = mid.aux_flip;
        res_next.hop_channel  = mid.hop_channel;
        res_next.hop_valid    = mid.hop_valid;
        if (mid.scale == SCALE_NONE)
        begin
            res_next.roll_cmd  = mid.roll_cmd;
            res_next.pitch_cmd = mid.pitch_cmd;
            res_next.yaw_cmd   = mid.yaw_cmd;
        end
        else
        begin
            res_next.roll_cmd  = scale_axis(mid.roll_cmd, k);
            res_next.pitch_cmd = scale_axis(mid.pitch_cmd, k);
            res_next.yaw_cmd   = scale_axis(mid.yaw_cmd, k);
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            res_reg <= res_next;
        end
    end

    assign res = res_reg;

endmodule

// ===== design/rc_command_packet_decoder.sv =====
// Radio command packet decoder, top level.
// Payload bytes enter on s_*, one transfer per byte; s_tuser marks the first
// byte of a packet. When a packet completes (9 bytes in protocol mode 0, 19 in
// mode 1) one command result leaves on m_*; other bytes give no result.
// Configuration registers (protocol mode, bind ID bytes) are for the user to write on cfg_*
// only while the block is idle; the block itself does not enforce this. cfg_ready is always high.
// Throughput: one byte per cycle while s_tready is high. m_tvalid rises once the result of
// the completing byte has passed the decode register, then the scale/output register.
// s_tready drops only while both result stages are full and m_tready is low;
// no byte or result is lost or repeated during a stall.
// Reset (rst_n low, asynchronous) clears the byte count and flip latch, sets
// the hop index to 1 and protocol mode to 1, and empties the result stages.
// Depends on rcpd_pkg, rcpd_collect, rcpd_decode, rcpd_scale.
module rc_command_packet_decoder (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] payload_byte
    input  logic        s_tuser,   // [0] packet_start
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [63:0] m_tdata,   // [9:0] throttle_cmd, [19:10] roll_cmd, [29:20] pitch_cmd,
                                   // [39:30] yaw_cmd, [49:40] aux_flip, [56:50] hop_channel
    output logic        m_tuser,   // [0] hop_valid
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [7:0]  cfg_data
);
    import rcpd_pkg::*;

    logic       mode_reg;
    logic [7:0] bind_lo_reg;
    logic [7:0] bind_hi_reg;
    logic       mid_v_reg;
    logic       mid_v_next;
    logic       out_v_reg;
    logic       out_v_next;
    logic       out_adv;
    logic       mid_adv;
    logic       accept;

    frame_t     frame;
    mid_t       mid;
    result_t    res;

    assign cfg_ready = 1'b1;
    assign out_adv   = !out_v_reg || m_tready;
    assign mid_adv   = !mid_v_reg || out_adv;
    assign s_tready  = mid_adv;
    assign accept    = s_tvalid && s_tready;

    always_comb
    begin
        mid_v_next = mid_adv ? frame.complete : mid_v_reg;
        out_v_next = out_adv ? mid_v_reg : out_v_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg    <= 1'b1;
            bind_lo_reg <= '0;
            bind_hi_reg <= '0;
            mid_v_reg   <= 1'b0;
            out_v_reg   <= 1'b0;
        end
        else
        begin
            mid_v_reg <= mid_v_next;
            out_v_reg <= out_v_next;
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    CFG_PROTOCOL_MODE: mode_reg    <= cfg_data[0];
                    CFG_BIND_ID_LOW:   bind_lo_reg <= cfg_data;
                    CFG_BIND_ID_HIGH:  bind_hi_reg <= cfg_data;
                    default:           ;
                endcase
            end
        end
    end

    rcpd_collect u_collect (
        .clk           (clk),
        .rst_n         (rst_n),
        .accept        (accept),
        .payload_byte  (s_tdata),
        .packet_start  (s_tuser),
        .protocol_mode (mode_reg),
        .frame         (frame)
    );

    rcpd_decode u_decode (
        .clk           (clk),
        .rst_n         (rst_n),
        .frame         (frame),
        .protocol_mode (mode_reg),
        .bind_id_low   (bind_lo_reg),
        .bind_id_high  (bind_hi_reg),
        .mid           (mid)
    );

    rcpd_scale u_scale (
        .clk  (clk),
        .load (mid_v_reg && out_adv),
        .mid  (mid),
        .res  (res)
    );

    assign m_tvalid = out_v_reg;
    assign m_tdata  = {7'd0, res.hop_channel, res.aux_flip, res.yaw_cmd,
                       res.pitch_cmd, res.roll_cmd, res.throttle_cmd};
    assign m_tuser  = res.hop_valid;

`ifndef NO_ASSERTIONS
    a_stall_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        !s_tready |-> (mid_v_reg && m_tvalid && !m_tready))
        else $error("input stalled while a result stage is free");

    a_throttle_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tdata[9:0] <= 10'd1000))
        else $error("throttle out of range");

    a_hop_off_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tuser) |-> (m_tdata[56:50] == 7'd0))
        else $error("hop channel nonzero without hop_valid");

    a_hop_on_range: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tuser) |-> (m_tdata[56:50] >= 7'd3))
        else $error("hop channel below table minimum");
`endif

endmodule
